/* hdl/frame_rate_meter_core_defines.svh */
// Assertion macros used by the checker of the frame rate meter.
`ifndef FRAME_RATE_METER_CORE_DEFINES_SVH
`define FRAME_RATE_METER_CORE_DEFINES_SVH

// Clocked assertion, off while reset is held.
`define FRM_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("frame_rate_meter_core: assertion failed");

// Clocked assertion that also holds during reset.
`define FRM_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("frame_rate_meter_core: reset assertion failed");

`endif

/* hdl/frm_pkg.sv */
package frm_pkg;

	localparam int unsigned WINDOW  = 64;
	localparam int unsigned SLOT_W  = $clog2(WINDOW);
	localparam int unsigned CNT_W   = $clog2(WINDOW + 1);
	localparam int unsigned TS_W    = 64;
	localparam int unsigned DELTA_W = 32;
	localparam int unsigned SUM_W   = DELTA_W + $clog2(WINDOW);

	// 1e9 * 2^16, the numerator of the rate for one sample
	localparam int unsigned NSQ_W = 46;
	localparam logic [NSQ_W-1:0] NS_PER_SEC_Q16 = 46'd65536000000000;

	// dividend width shared by both dividers: up to WINDOW * 1e9 * 2^16
	localparam int unsigned NUM_W  = NSQ_W + CNT_W;
	localparam int unsigned QCNT_W = $clog2(NUM_W + 1);

	localparam logic [DELTA_W-1:0] FIRST_DELTA_RST = 32'd16666667;
	localparam logic [DELTA_W-1:0] TOP32           = 32'hFFFF_FFFF;

	typedef struct packed {
		logic               re;
		logic               we;
		logic [SLOT_W-1:0]  addr;
		logic [DELTA_W-1:0] wdata;
	} frm_ram_req_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] dividend;
		logic [SUM_W-1:0] divisor;
	} frm_div_req_t;

endpackage

/* hdl/frm_ring_ram.sv */
module frm_ring_ram (
	input  logic                         clk,
	input  frm_pkg::frm_ram_req_t        req,
	output logic [frm_pkg::DELTA_W-1:0]  rdata
);
	import frm_pkg::*;

	logic [DELTA_W-1:0] mem [WINDOW];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.addr];
		end
	end

endmodule

/* hdl/frm_divider.sv */
module frm_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  frm_pkg::frm_div_req_t      req,
	output logic                       done,
	output logic [frm_pkg::NUM_W-1:0]  quotient
);
	import frm_pkg::*;

	localparam logic [QCNT_W-1:0] LAST = QCNT_W'(NUM_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]  quo_q;
	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  dvs_q;

	logic [SUM_W:0]    rem_sh;
	logic [SUM_W:0]    rem_sub;
	logic              ge;

	// one quotient bit per cycle, restoring
	always_comb begin
		rem_sh  = {rem_q, quo_q[NUM_W-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* hdl/frame_rate_meter_core.sv */
// Frame rate meter.
// Input channel: one beat per frame tick carries timestamp_ns. The first beat
// after reset sets the time origin. Each input beat gives exactly one output
// beat with delta_ns, average_ns (mean delta over the last 64 frames or fewer),
// rate_q16 (frames per second, unsigned Q16.16, saturating) and elapsed_ns.
// cfg_we/cfg_wdata write first_delta_ns, the delta reported while the last elapsed
// time is zero (the first two frames); write it only while no frame is in flight.
// One frame is in flight at a time, so the block takes no new beat until the
// last one is through. The time per frame is set by the two 53-step bit-serial
// dividers (average and rate) that run side by side; the delta ring is read
// (S_ELAPSED) and rewritten (S_SUM) in the states before they start.
// A result waits in the output register while out_stall is high; the next frame
// is taken only once its result has moved into that register.
// Reset (arst_n low, asynchronous) clears origin, window sum and sample count,
// and sets first_delta_ns to 16666667. Ring slots not yet written read as zero
// through the sample count, so no clearing pass is needed.
module frame_rate_meter_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [frm_pkg::DELTA_W-1:0]  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [frm_pkg::TS_W-1:0]     timestamp_ns,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [frm_pkg::DELTA_W-1:0]  delta_ns,
	output logic [frm_pkg::DELTA_W-1:0]  average_ns,
	output logic [frm_pkg::DELTA_W-1:0]  rate_q16,
	output logic [frm_pkg::TS_W-1:0]     elapsed_ns
);
	import frm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ELAPSED,
		S_DELTA,
		S_SUM,
		S_START,
		S_DIV,
		S_HOLD
	} state_t;

	state_t             state_q;
	logic [DELTA_W-1:0] first_delta_q;
	logic               started_q;
	logic [TS_W-1:0]    origin_q;
	logic [TS_W-1:0]    last_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [NUM_W-1:0]   num_q;

	logic [TS_W-1:0]    ts_q;
	logic [TS_W-1:0]    elapsed_q;
	logic [DELTA_W-1:0] delta_q;
	logic [DELTA_W-1:0] old_q;

	logic               out_valid_q;
	logic [DELTA_W-1:0] delta_out_q;
	logic [DELTA_W-1:0] avg_out_q;
	logic [DELTA_W-1:0] rate_out_q;
	logic [TS_W-1:0]    elapsed_out_q;

	frm_ram_req_t       ram_req;
	logic [DELTA_W-1:0] ram_rdata;
	frm_div_req_t       avg_req;
	frm_div_req_t       rate_req;
	logic               avg_done;
	logic               rate_done;
	logic [NUM_W-1:0]   avg_quo;
	logic [NUM_W-1:0]   rate_quo;

	logic [TS_W-1:0]    diff;
	logic [DELTA_W-1:0] delta_nxt;
	logic [DELTA_W-1:0] rate_sat;
	logic               out_free;
	logic               div_done;
	logic               out_load;
	logic               full;

	always_comb begin
		diff = elapsed_q - last_q;
		if (last_q == '0) begin
			delta_nxt = first_delta_q;
		end else if (|diff[TS_W-1:DELTA_W]) begin
			delta_nxt = TOP32;
		end else begin
			delta_nxt = diff[DELTA_W-1:0];
		end
		full     = count_q == CNT_W'(WINDOW);
		out_free = !out_valid_q || !out_stall;
		div_done = avg_done && rate_done;
		out_load = ((state_q == S_HOLD) || (state_q == S_DIV && div_done)) && out_free;
		if ((sum_q == '0) || (|rate_quo[NUM_W-1:DELTA_W])) begin
			rate_sat = TOP32;
		end else begin
			rate_sat = rate_quo[DELTA_W-1:0];
		end
	end

	always_comb begin
		ram_req.re    = state_q == S_ELAPSED;
		ram_req.we    = state_q == S_SUM;
		ram_req.addr  = slot_q;
		ram_req.wdata = delta_q;

		avg_req.start    = state_q == S_START;
		avg_req.dividend = NUM_W'(sum_q);
		avg_req.divisor  = SUM_W'(count_q);

		rate_req.start    = state_q == S_START;
		rate_req.dividend = num_q;
		rate_req.divisor  = sum_q;
	end

	frm_ring_ram u_ring (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	frm_divider u_avg_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (avg_req),
		.done     (avg_done),
		.quotient (avg_quo)
	);

	frm_divider u_rate_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (rate_req),
		.done     (rate_done),
		.quotient (rate_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			first_delta_q <= FIRST_DELTA_RST;
			started_q     <= 1'b0;
			origin_q      <= '0;
			last_q        <= '0;
			slot_q        <= '0;
			count_q       <= '0;
			sum_q         <= '0;
			num_q         <= '0;
			out_valid_q   <= 1'b0;
			delta_out_q   <= '0;
			avg_out_q     <= '0;
			rate_out_q    <= '0;
			elapsed_out_q <= '0;
		end else begin
			if (cfg_we) begin
				first_delta_q <= cfg_wdata;
			end
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ELAPSED;
					end
				end
				S_ELAPSED: begin
					if (!started_q) begin
						origin_q  <= ts_q;
						started_q <= 1'b1;
					end
					state_q <= S_DELTA;
				end
				S_DELTA: begin
					last_q  <= elapsed_q;
					state_q <= S_SUM;
				end
				S_SUM: begin
					sum_q  <= sum_q - SUM_W'(old_q) + SUM_W'(delta_q);
					slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					if (!full) begin
						count_q <= count_q + 1'b1;
						num_q   <= num_q + NUM_W'(NS_PER_SEC_Q16);
					end
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV, S_HOLD: begin
					if (out_load) begin
						out_valid_q   <= 1'b1;
						delta_out_q   <= delta_q;
						avg_out_q     <= avg_quo[DELTA_W-1:0];
						rate_out_q    <= rate_sat;
						elapsed_out_q <= elapsed_q;
						state_q       <= S_IDLE;
					end else if (div_done) begin
						state_q <= S_HOLD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// frame payload, held through the item
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			ts_q <= timestamp_ns;
		end
		if (state_q == S_ELAPSED) begin
			elapsed_q <= started_q ? ts_q - origin_q : '0;
		end
		if (state_q == S_DELTA) begin
			delta_q <= delta_nxt;
			// slots past the fill count are not yet written and are taken as zero
			old_q   <= full ? ram_rdata : '0;
		end
	end

	assign in_stall   = state_q != S_IDLE;
	assign out_valid  = out_valid_q;
	assign delta_ns   = delta_out_q;
	assign average_ns = avg_out_q;
	assign rate_q16   = rate_out_q;
	assign elapsed_ns = elapsed_out_q;

endmodule

/* hdl/frm_checker.sv */
`include "frame_rate_meter_core_defines.svh"

module frm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_we,
	input logic [frm_pkg::DELTA_W-1:0]  cfg_wdata,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [frm_pkg::TS_W-1:0]     timestamp_ns,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [frm_pkg::DELTA_W-1:0]  delta_ns,
	input logic [frm_pkg::DELTA_W-1:0]  average_ns,
	input logic [frm_pkg::DELTA_W-1:0]  rate_q16,
	input logic [frm_pkg::TS_W-1:0]     elapsed_ns
);
	import frm_pkg::*;

	// a frame in flight blocks the next one
	`FRM_ASSERT(a_accept_then_busy, in_valid && !in_stall |=> in_stall)

	// a finished frame waits behind a stalled result
	`FRM_ASSERT(a_hold_behind_stall, out_valid && out_stall && in_stall |=> in_stall)

	// a mean under 1e9 / 2^16 ns gives a rate past the top of Q16.16
	`FRM_ASSERT(a_rate_saturates, out_valid && average_ns < 32'd15258 |-> rate_q16 == TOP32)

	// a stalled result beat holds
	`FRM_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(delta_ns) && $stable(elapsed_ns))

	`FRM_ASSERT_RST(a_reset_no_out, !arst_n |-> !out_valid)

endmodule

bind frame_rate_meter_core frm_checker u_frm_checker (.*);
